// ===== src/tape_controller_read_path_macros.svh =====
// ----------------------------------------------------------------------------
// Tape controller read path assertion macros
// Clocked implication checks used by the read path top level.
// ----------------------------------------------------------------------------
`ifndef TAPE_CONTROLLER_READ_PATH_MACROS_SVH
`define TAPE_CONTROLLER_READ_PATH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TCRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tape read path check failed");

// Next-cycle implication, checked out of reset.
`define TCRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tape read path check failed");

`endif

// ===== src/tcrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Tape read path package
// Item types, operation and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcrp_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  dev_cmd;
    logic [1:0]  media_result;
    logic [14:0] record_bytes;
    logic [13:0] byte_index;
    logic [7:0]  tape_byte;
    logic        write_protected;
    logic        at_load_point;
  } in_t;

  typedef struct packed {
    logic [11:0] status_word;
    logic        failed;
    logic        read_armed;
    logic [35:0] data_word;
    logic        word_valid;
  } out_t;

  // Operation codes
  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  // Device command codes
  localparam logic [5:0] CMD_STATUS = 6'd0;
  localparam logic [5:0] CMD_READ   = 6'd5;
  localparam logic [5:0] CMD_RESET  = 6'd32;

  // Media outcome codes
  localparam logic [1:0] MEDIA_OK  = 2'd0;
  localparam logic [1:0] MEDIA_EOF = 2'd1;
  localparam logic [1:0] MEDIA_ERR = 2'd2;

  // Status words
  localparam logic [11:0] STAT_OK     = 12'o4000;
  localparam logic [11:0] STAT_EOF    = 12'o4423;
  localparam logic [11:0] STAT_RDERR  = 12'o5001;
  localparam logic [11:0] STAT_REJECT = 12'o4501;
  localparam logic [11:0] STAT_INCONS = 12'o5302;

  // Index of the last byte read per word: four whole bytes plus one shared nibble byte
  localparam logic [2:0] RD_LAST = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       emit_now;
    logic       issue_rd;
    logic [2:0] rd_sel;
    logic       capture;
    logic       emit_word;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       fetch_ok;
  } dp_status_t;

endpackage

// ===== src/tcrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tape read path controller
// Accepts items and sequences the five byte reads of a data request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcrp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  tcrp_pkg::dp_status_t   status_i,
  output tcrp_pkg::ctrl_cmd_t    cmd_o
);

  tcrp_pkg::state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic accept;
  logic go_fetch;

  assign accept   = start && (state_q == tcrp_pkg::S_IDLE);
  assign go_fetch = accept && (status_i.op == tcrp_pkg::OP_DATA) && status_i.fetch_ok;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      tcrp_pkg::S_IDLE: begin
        cnt_d = 3'd0;
        if (go_fetch) begin
          state_d = tcrp_pkg::S_FETCH;
        end
      end
      tcrp_pkg::S_FETCH: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == tcrp_pkg::RD_LAST) begin
          state_d = tcrp_pkg::S_DRAIN;
        end
      end
      tcrp_pkg::S_DRAIN: begin
        state_d = tcrp_pkg::S_IDLE;
      end
      default: begin
        state_d = tcrp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.emit_now = accept && ((status_i.op == tcrp_pkg::OP_CMD) ||
                                ((status_i.op == tcrp_pkg::OP_DATA) && !status_i.fetch_ok));
    cmd_o.rd_sel   = cnt_q;
    case (state_q)
      tcrp_pkg::S_FETCH: begin
        cmd_o.issue_rd = 1'b1;
        // first read has no data back yet
        cmd_o.capture  = (cnt_q != 3'd0);
      end
      tcrp_pkg::S_DRAIN: begin
        cmd_o.capture   = 1'b1;
        cmd_o.emit_word = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_q != tcrp_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcrp_pkg::S_IDLE;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== src/tcrp_dp.sv =====
// ----------------------------------------------------------------------------
// Tape read path datapath
// Record buffer, transfer state, status decode and 36-bit word unpacking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcrp_dp #(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcrp_pkg::in_t          item_i,
  input  tcrp_pkg::ctrl_cmd_t    cmd_i,
  output tcrp_pkg::dp_status_t   status_o,
  output logic                   result_strobe_o,
  output tcrp_pkg::out_t         result_o
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  logic [7:0] mem [BUFFER_BYTES];

  logic [14:0] len_q;
  logic [12:0] words_q;
  logic        mode_q;
  logic        strobe_q;
  tcrp_pkg::out_t res_q, res_d;
  logic [7:0]  rd_data_q;
  logic        in_range_q;
  logic [39:0] acc_q, acc_d;

  logic [16:0] mul9;
  logic [15:0] done;
  logic        fetch_ok;
  logic [31:0] rlen_ext;
  logic [14:0] rlen_sat;
  logic [31:0] widx_ext;
  logic        wr_en;
  logic [11:0] half;
  logic [15:0] base;
  logic [15:0] pos;
  logic [31:0] pos_ext;
  logic        rd_in_range;
  logic [7:0]  cap_byte;
  logic [35:0] word;
  logic        commit_read;

  // Bytes consumed so far: ceil(words * 4.5)
  assign mul9     = {1'b0, words_q, 3'b000} + {4'b0000, words_q} + 17'd1;
  assign done     = mul9[16:1];
  assign fetch_ok = mode_q && (done < {1'b0, len_q});

  assign status_o.op       = item_i.op;
  assign status_o.fetch_ok = fetch_ok;

  assign rlen_ext = {17'd0, item_i.record_bytes};
  assign rlen_sat = (rlen_ext > BUFFER_BYTES) ? 15'(BUFFER_BYTES) : item_i.record_bytes;

  assign widx_ext = {18'd0, item_i.byte_index};
  assign wr_en    = cmd_i.accept && (item_i.op == tcrp_pkg::OP_LOAD) &&
                    (widx_ext < BUFFER_BYTES);

  assign commit_read = cmd_i.accept && (item_i.op == tcrp_pkg::OP_CMD) &&
                       (item_i.dev_cmd == tcrp_pkg::CMD_READ) &&
                       (item_i.media_result == tcrp_pkg::MEDIA_OK);

  // Odd words start at the nibble byte, four bytes into the pair
  assign half        = words_q[12:1];
  assign base        = {1'b0, half, 3'b000} + {4'b0000, half};
  assign pos         = base + {13'd0, words_q[0], 2'b00} + {13'd0, cmd_i.rd_sel};
  assign pos_ext     = {16'd0, pos};
  assign rd_in_range = (pos_ext < BUFFER_BYTES);

  assign cap_byte = in_range_q ? rd_data_q : 8'h00;
  assign acc_d    = {acc_q[31:0], cap_byte};
  assign word     = words_q[0] ? acc_d[35:0] : acc_d[39:4];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[widx_ext[AW-1:0]] <= item_i.tape_byte;
    end
    if (cmd_i.issue_rd) begin
      rd_data_q  <= mem[pos_ext[AW-1:0]];
      in_range_q <= rd_in_range;
    end
  end

  // Status result of an accepted command or data request
  always_comb begin
    res_d = '0;
    case (item_i.op)
      tcrp_pkg::OP_CMD: begin
        case (item_i.dev_cmd)
          tcrp_pkg::CMD_STATUS: begin
            res_d.status_word = tcrp_pkg::STAT_OK |
                                {10'd0, item_i.at_load_point, item_i.write_protected};
          end
          tcrp_pkg::CMD_READ: begin
            case (item_i.media_result)
              tcrp_pkg::MEDIA_OK: begin
                res_d.status_word = tcrp_pkg::STAT_OK | {11'd0, item_i.write_protected};
                res_d.read_armed  = 1'b1;
              end
              tcrp_pkg::MEDIA_EOF: begin
                res_d.status_word = tcrp_pkg::STAT_EOF;
              end
              default: begin
                res_d.status_word = tcrp_pkg::STAT_RDERR;
                res_d.failed      = 1'b1;
              end
            endcase
          end
          tcrp_pkg::CMD_RESET: begin
            res_d.status_word = tcrp_pkg::STAT_OK | {11'd0, item_i.write_protected};
          end
          default: begin
            res_d.status_word = tcrp_pkg::STAT_REJECT;
            res_d.failed      = 1'b1;
          end
        endcase
      end
      default: begin
        if (!mode_q) begin
          res_d.status_word = tcrp_pkg::STAT_INCONS;
          res_d.failed      = 1'b1;
        end else begin
          res_d.status_word = tcrp_pkg::STAT_OK | {11'd0, item_i.write_protected};
          res_d.failed      = !fetch_ok;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_q <= res_d;
    end else if (cmd_i.emit_word) begin
      res_q.data_word  <= word;
      res_q.word_valid <= 1'b1;
    end
    if (cmd_i.capture) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      words_q  <= '0;
      mode_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_now || cmd_i.emit_word;
      if (commit_read) begin
        len_q   <= rlen_sat;
        words_q <= '0;
        mode_q  <= 1'b1;
      end else if (cmd_i.emit_word) begin
        words_q <= words_q + 13'd1;
      end
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

endmodule

// ===== src/tape_controller_read_path.sv =====
// ----------------------------------------------------------------------------
// Tape controller read path
// One tape unit: record buffer loads, device commands and word unpacking.
// ----------------------------------------------------------------------------
//  channel   signals                         handshake
//  item      start, busy, item_i             taken when start high, busy low
//  result    result_strobe_o, result_o       one-cycle strobe, no back-pressure
//
//  Byte loads leave busy low. Commands and refused data requests give their
//  result in the cycle after the item is taken, with busy low. A data request
//  that returns a word holds busy while five bytes come through the single
//  buffer read port, one a cycle; its result shows in the cycle busy drops.
//  Reset clears mode, length and position; the buffer is not cleared.
`timescale 1ns / 1ps

`include "tape_controller_read_path_macros.svh"

module tape_controller_read_path #(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tcrp_pkg::in_t    item_i,
  output logic             result_strobe_o,
  output tcrp_pkg::out_t   result_o
);

  tcrp_pkg::ctrl_cmd_t  cmd;
  tcrp_pkg::dp_status_t dp_status;

  tcrp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  tcrp_dp #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item_i),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

  // A result never shows while a word fetch is in flight
  `TCRP_ASSERT_NOW(a_no_result_while_busy, clk_i, rst_ni, busy, !result_strobe_o)
  // An empty result carries no word bits
  `TCRP_ASSERT_NOW(a_empty_word_zero, clk_i, rst_ni,
                   result_strobe_o && !result_o.word_valid, result_o.data_word == 36'd0)
  // Byte loads never stall the unit
  `TCRP_ASSERT_NEXT(a_load_no_stall, clk_i, rst_ni,
                    start && !busy && (item_i.op == tcrp_pkg::OP_LOAD), !busy)

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Tape controller read path testbench
// Drives commands, record byte loads and word requests through the start/busy
// handshake, predicts each status result in a shadow model of the unit and
// compares every strobed result with the oldest prediction. Covers directed
// corner cases, random record sequences with noise, and an oversized read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int BUF_BYTES   = 16384;
  localparam int RAND_ITEMS  = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [1:0] MEDIA_SPARE = 2'd3;
  localparam logic [5:0] CMD_BAD_HI  = 6'd63;
  localparam logic [5:0] CMD_BAD_LO  = 6'd1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  tcrp_pkg::in_t  item_i = '0;
  logic busy;
  logic result_strobe_o;
  tcrp_pkg::out_t result_o;

  tape_controller_read_path #(
    .BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  always #4 clk_i = ~clk_i;

  // Items waiting to be driven, and status results still owed by the unit
  tcrp_pkg::in_t  tape_items[$];
  tcrp_pkg::out_t unit_answers[$];

  // Shadow of the unit, advanced as beats are accepted
  logic [7:0] tape_mem [0:BUF_BYTES-1];
  int         unit_len     = 0;
  int         unit_words   = 0;
  bit         unit_reading = 1'b0;

  // Stimulus-side view of the same state, used to keep reads on loaded bytes
  bit gen_written [0:BUF_BYTES-1];
  int gen_len   = 0;
  int gen_words = 0;
  bit gen_mode  = 1'b0;
  int gen_items = 0;

  int mismatches   = 0;
  int items_taken  = 0;
  int results_seen = 0;
  int words_seen   = 0;
  int idle_left    = 0;
  int calm_left    = 0;
  int stall_cycles = 0;

  function automatic logic [7:0] byte_at(input int pos);
    if (pos >= BUF_BYTES) return 8'd0;
    return tape_mem[pos];
  endfunction

  // Two words share nine bytes; the odd word starts at the low nibble of byte 4
  function automatic logic [35:0] word_at(input int w);
    int base;
    logic [7:0] b0, b1, b2, b3, b4;
    base = (w / 2) * 9 + ((w % 2 != 0) ? 4 : 0);
    b0 = byte_at(base);
    b1 = byte_at(base + 1);
    b2 = byte_at(base + 2);
    b3 = byte_at(base + 3);
    b4 = byte_at(base + 4);
    if (w % 2 != 0) return {b0[3:0], b1, b2, b3, b4};
    return {b0, b1, b2, b3, b4[7:4]};
  endfunction

  task automatic run_unit(input tcrp_pkg::in_t it);
    tcrp_pkg::out_t ans;
    int   done;
    ans = '0;
    if (it.op == tcrp_pkg::OP_LOAD) begin
      tape_mem[it.byte_index] = it.tape_byte;
    end else if (it.op == tcrp_pkg::OP_CMD || it.op == tcrp_pkg::OP_DATA) begin
      if (it.op == tcrp_pkg::OP_CMD) begin
        if (it.dev_cmd == tcrp_pkg::CMD_STATUS) begin
          ans.status_word = tcrp_pkg::STAT_OK |
                            {10'd0, it.at_load_point, it.write_protected};
        end else if (it.dev_cmd == tcrp_pkg::CMD_READ) begin
          if (it.media_result == tcrp_pkg::MEDIA_OK) begin
            unit_len     = (int'(it.record_bytes) > BUF_BYTES) ? BUF_BYTES :
                           int'(it.record_bytes);
            unit_words   = 0;
            unit_reading = 1'b1;
            ans.status_word = tcrp_pkg::STAT_OK | {11'd0, it.write_protected};
            ans.read_armed  = 1'b1;
          end else if (it.media_result == tcrp_pkg::MEDIA_EOF) begin
            ans.status_word = tcrp_pkg::STAT_EOF;
          end else begin
            ans.status_word = tcrp_pkg::STAT_RDERR;
            ans.failed      = 1'b1;
          end
        end else if (it.dev_cmd == tcrp_pkg::CMD_RESET) begin
          ans.status_word = tcrp_pkg::STAT_OK | {11'd0, it.write_protected};
        end else begin
          ans.status_word = tcrp_pkg::STAT_REJECT;
          ans.failed      = 1'b1;
        end
      end else if (!unit_reading) begin
        ans.status_word = tcrp_pkg::STAT_INCONS;
        ans.failed      = 1'b1;
      end else begin
        done = (unit_words * 9 + 1) / 2;
        ans.status_word = tcrp_pkg::STAT_OK | {11'd0, it.write_protected};
        if (done >= unit_len) begin
          ans.failed = 1'b1;
        end else begin
          ans.data_word  = word_at(unit_words);
          ans.word_valid = 1'b1;
          unit_words++;
        end
      end
      unit_answers.push_back(ans);
    end
  endtask

  function automatic bit gen_fetches();
    return gen_mode && ((gen_words * 9 + 1) / 2 < gen_len);
  endfunction

  function automatic tcrp_pkg::in_t rand_item(input logic [1:0] op);
    tcrp_pkg::in_t it;
    it.op              = op;
    it.dev_cmd         = 6'($urandom_range(0, 63));
    it.media_result    = 2'($urandom_range(0, 3));
    it.record_bytes    = 15'($urandom_range(0, 32767));
    it.byte_index      = 14'($urandom_range(0, BUF_BYTES - 1));
    it.tape_byte       = 8'($urandom_range(0, 255));
    it.write_protected = 1'($urandom_range(0, 1));
    it.at_load_point   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic push_item(input tcrp_pkg::in_t it);
    tape_items.push_back(it);
    if (it.op != OP_SPARE) gen_items++;
    if (it.op == tcrp_pkg::OP_LOAD) begin
      gen_written[it.byte_index] = 1'b1;
    end else if (it.op == tcrp_pkg::OP_CMD && it.dev_cmd == tcrp_pkg::CMD_READ &&
                 it.media_result == tcrp_pkg::MEDIA_OK) begin
      gen_len   = (int'(it.record_bytes) > BUF_BYTES) ? BUF_BYTES : int'(it.record_bytes);
      gen_words = 0;
      gen_mode  = 1'b1;
    end else if (it.op == tcrp_pkg::OP_DATA && gen_fetches()) begin
      gen_words++;
    end
  endtask

  task automatic push_load(input int idx, input int val);
    tcrp_pkg::in_t it;
    it = rand_item(tcrp_pkg::OP_LOAD);
    it.byte_index = 14'(idx);
    it.tape_byte  = 8'(val);
    push_item(it);
  endtask

  task automatic push_cmd(input logic [5:0] cmd, input logic [1:0] media, input int len);
    tcrp_pkg::in_t it;
    it = rand_item(tcrp_pkg::OP_CMD);
    it.dev_cmd      = cmd;
    it.media_result = media;
    it.record_bytes = 15'(len);
    push_item(it);
  endtask

  // Load any byte the next word will fetch that has never been written
  task automatic push_data();
    int base;
    int pos;
    if (gen_fetches()) begin
      base = (gen_words / 2) * 9 + ((gen_words % 2 != 0) ? 4 : 0);
      for (pos = base; pos < base + 5; pos++)
        if (pos < BUF_BYTES && !gen_written[pos]) push_load(pos, $urandom_range(0, 255));
    end
    push_item(rand_item(tcrp_pkg::OP_DATA));
  endtask

  function automatic int next_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm_left = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag(input string field, input logic [35:0] want_v, input logic [35:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : drive
    if (rst_ni) begin
      if (start && busy) begin
        // hold the beat until the unit frees up
      end else begin
        if (start) begin
          run_unit(item_i);
          items_taken++;
        end
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start     <= 1'b0;
        end else if (tape_items.size() > 0) begin
          item_i    <= tape_items.pop_front();
          start     <= 1'b1;
          idle_left <= next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check
    tcrp_pkg::out_t want;
    if (rst_ni && result_strobe_o) begin
      if (unit_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status 0x%0h word 0x%0h",
                 $time, result_o.status_word, result_o.data_word);
        mismatches++;
      end else begin
        want = unit_answers.pop_front();
        results_seen++;
        if (want.word_valid) words_seen++;
        flag("status_word", 36'(want.status_word), 36'(result_o.status_word));
        flag("failed",      36'(want.failed),      36'(result_o.failed));
        flag("read_armed",  36'(want.read_armed),  36'(result_o.read_armed));
        flag("data_word",   want.data_word,        result_o.data_word);
        flag("word_valid",  36'(want.word_valid),  36'(result_o.word_valid));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || result_strobe_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    tcrp_pkg::in_t it;
    int  i, len, cut, n, roll, stop_at;

    // Requests before any read, status variants, rejects, failed reads
    push_data();
    it = rand_item(tcrp_pkg::OP_CMD);
    it.dev_cmd = tcrp_pkg::CMD_STATUS;
    it.write_protected = 1'b0;
    it.at_load_point   = 1'b0;
    push_item(it);
    it.write_protected = 1'b1;
    it.at_load_point   = 1'b1;
    push_item(it);
    it.dev_cmd = tcrp_pkg::CMD_RESET;
    push_item(it);
    push_cmd(CMD_BAD_HI, tcrp_pkg::MEDIA_OK, 9);
    push_cmd(CMD_BAD_LO, tcrp_pkg::MEDIA_OK, 9);
    push_cmd(tcrp_pkg::CMD_READ, tcrp_pkg::MEDIA_EOF, 9);
    push_cmd(tcrp_pkg::CMD_READ, tcrp_pkg::MEDIA_ERR, 9);
    push_cmd(tcrp_pkg::CMD_READ, MEDIA_SPARE, 9);
    push_data();
    push_item(rand_item(OP_SPARE));
    // One packed pair: an all-ones word, then a word of one set nibble over zeros, read out and run dry
    for (i = 0; i < 9; i++) push_load(i, (i < 5) ? 255 : 0);
    push_cmd(tcrp_pkg::CMD_READ, tcrp_pkg::MEDIA_OK, 9);
    push_data();
    push_data();
    push_data();
    push_cmd(tcrp_pkg::CMD_READ, tcrp_pkg::MEDIA_OK, 0);
    push_data();

    stop_at = gen_items + RAND_ITEMS;
    while (gen_items < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300) : $urandom_range(0, 48);
        if ($urandom_range(0, 1) != 0) begin
          for (i = 0; i < len; i++) push_load(i, $urandom_range(0, 255));
        end else begin
          for (i = len - 1; i >= 0; i--) push_load(i, $urandom_range(0, 255));
        end
        if ($urandom_range(0, 3) == 0) push_item(rand_item(tcrp_pkg::OP_CMD));
        push_cmd(tcrp_pkg::CMD_READ,
                 ($urandom_range(0, 6) == 0) ? 2'($urandom_range(1, 3)) : tcrp_pkg::MEDIA_OK,
                 len);
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : -1;
        n = 0;
        while (gen_fetches() && n != cut) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            push_cmd(($urandom_range(0, 1) != 0) ? tcrp_pkg::CMD_STATUS : tcrp_pkg::CMD_RESET,
                     2'($urandom_range(0, 3)), $urandom_range(0, 32767));
          end else if (roll < 11) begin
            push_load($urandom_range(0, BUF_BYTES - 1), $urandom_range(0, 255));
          end
          push_data();
          n++;
        end
        if (cut < 0) repeat ($urandom_range(1, 2)) push_data();
      end else begin
        case ($urandom_range(0, 4))
          0: push_item(rand_item(tcrp_pkg::OP_CMD));
          1: push_item(rand_item(OP_SPARE));
          2: push_load($urandom_range(0, BUF_BYTES - 1), $urandom_range(0, 255));
          3: push_data();
          default: push_cmd(tcrp_pkg::CMD_STATUS, 2'($urandom_range(0, 3)),
                            $urandom_range(0, 32767));
        endcase
      end
    end

    // Oversized length saturates at the buffer size; take the opening words
    push_cmd(tcrp_pkg::CMD_READ, tcrp_pkg::MEDIA_OK, 32767);
    repeat (4) push_data();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (tape_items.size() != 0 || start) @(posedge clk_i);
    while (unit_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d beats taken, %0d results checked, %0d words unpacked",
             items_taken, results_seen, words_seen);
    $display("tb: ran corner commands, random records with noise, and an oversized read");
    if (mismatches == 0 && unit_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tcrp_pkg.sv
src/tcrp_ctrl.sv
src/tcrp_dp.sv
src/tape_controller_read_path.sv
test/tb.sv
